[rtl/core/itp_pkg.sv]
// package for the infix to postfix converter: types, codes and character helpers
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    typedef logic [2:0] t_op_code;

    localparam t_op_code OP_OPEN = 3'd0;
    localparam t_op_code OP_ADD  = 3'd1;
    localparam t_op_code OP_SUB  = 3'd2;
    localparam t_op_code OP_MUL  = 3'd3;
    localparam t_op_code OP_DIV  = 3'd4;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef enum logic [2:0] {
        K_LETTER,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_DONE,
        S_FLUSH
    } t_state;

    function automatic t_kind classify(input logic [7:0] ch);
        t_kind k;
        case (ch) inside
            [8'h41:8'h5A], [8'h61:8'h7A]:    k = K_LETTER;
            CH_OPEN:                         k = K_OPEN;
            CH_CLOSE:                        k = K_CLOSE;
            CH_ADD, CH_SUB, CH_MUL, CH_DIV:  k = K_OPER;
            default:                         k = K_OTHER;
        endcase
        return k;
    endfunction

    function automatic t_op_code op_code(input logic [7:0] ch);
        t_op_code c;
        unique case (ch)
            CH_ADD:  c = OP_ADD;
            CH_SUB:  c = OP_SUB;
            CH_MUL:  c = OP_MUL;
            CH_DIV:  c = OP_DIV;
            default: c = OP_OPEN;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] code_char(input t_op_code c);
        logic [7:0] ch;
        unique case (c)
            OP_OPEN: ch = CH_OPEN;
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // 1 for high precedence (mul, div)
    function automatic logic prec_hi(input t_op_code c);
        return (c >= OP_MUL);
    endfunction

endpackage

`default_nettype wire

[rtl/core/infix_to_postfix_converter_unit.sv]
// infix to postfix converter: shunting-yard with the operator stack in a synchronous memory
//
//  port group  | dir | fields (low bit up)                        | tlast         | tuser
//  s_axis_*    | in  | tdata: symbol[7:0]                         | end_of_input  | -
//  m_axis_*    | out | tdata: out_symbol[7:0], overflow, zeros    | end_of_output | has_symbol
//
//  a word steps through S_IDLE, S_WORK and S_DONE, popping stacked operators in S_WORK; a final
//  word then enters S_FLUSH, which pops every remaining stack entry and sends the end marker
//  a pop only lowers the stack count; the new top comes from the registered memory read
//  i_rst_n clears control state; the stack memory holds no reset value
//  a stalled output holds the sequencer until its word is taken
`default_nettype none

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // symbol
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_symbol, overflow, zero fill
    output logic             m_axis_tuser,   // has_symbol
    output logic             m_axis_tlast
);

    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    t_state          r_state, n_state;
    logic [7:0]      r_sym, n_sym;
    logic            r_last, n_last;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_pend_v, n_pend_v;
    logic [7:0]      r_pend_sym, n_pend_sym;
    logic            r_out_v, n_out_v;
    logic [7:0]      r_out_sym, n_out_sym;
    logic            r_out_has, n_out_has;
    logic            r_out_end, n_out_end;
    logic            r_out_ovf, n_out_ovf;

    t_op_code        mem [STACK_DEPTH];
    t_op_code        r_rd_data;
    logic            r_byp;
    t_op_code        r_byp_data;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_op_code        wr_data;
    logic [AW-1:0]   rd_addr;
    t_op_code        top;
    logic            o_free;
    logic            can_emit;
    logic            emit_req;
    logic [7:0]      emit_ch;
    logic            stack_full;
    logic            have_top;
    t_kind           kind;
    t_op_code        cur_op;

    assign top        = r_byp ? r_byp_data : r_rd_data;
    assign o_free     = !r_out_v || m_axis_tready;
    assign can_emit   = !r_pend_v || o_free;
    assign stack_full = (r_count == CW'(STACK_DEPTH));
    assign have_top   = (r_count != '0);
    assign kind       = classify(r_sym);
    assign cur_op     = op_code(r_sym);

    // read address always tracks the next top of stack
    assign rd_addr = (n_count == '0) ? '0 : AW'(n_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data  <= mem[rd_addr];
        r_byp_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_byp    <= wr_en && (wr_addr == rd_addr);
        end
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_pend_sym <= n_pend_sym;
        r_out_sym  <= n_out_sym;
        r_out_has  <= n_out_has;
        r_out_end  <= n_out_end;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state    = r_state;
        n_sym      = r_sym;
        n_last     = r_last;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_out_v    = r_out_v && !m_axis_tready;
        n_out_sym  = r_out_sym;
        n_out_has  = r_out_has;
        n_out_end  = r_out_end;
        n_out_ovf  = r_out_ovf;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = OP_OPEN;
        emit_req   = 1'b0;
        emit_ch    = code_char(top);
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_sym   = s_axis_tdata;
                    n_last  = s_axis_tlast;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                unique case (kind)
                    K_LETTER: begin
                        emit_req = 1'b1;
                        emit_ch  = r_sym;
                        if (can_emit) begin
                            n_state = S_DONE;
                        end
                    end
                    K_OPEN, K_OPER: begin
                        if (kind == K_OPER && have_top && top != OP_OPEN &&
                            (prec_hi(top) || !prec_hi(cur_op))) begin
                            emit_req = 1'b1;
                            if (can_emit) begin
                                n_count = r_count - CW'(1);
                            end
                        end else begin
                            if (stack_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = (kind == K_OPER) ? cur_op : OP_OPEN;
                                n_count = r_count + CW'(1);
                            end
                            n_state = S_DONE;
                        end
                    end
                    K_CLOSE: begin
                        if (have_top && top != OP_OPEN) begin
                            emit_req = 1'b1;
                            if (can_emit) begin
                                n_count = r_count - CW'(1);
                            end
                        end else begin
                            if (have_top) begin
                                n_count = r_count - CW'(1);
                            end
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (r_last) begin
                    n_state = S_FLUSH;
                end else if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (o_free) begin
                    n_out_v   = 1'b1;
                    n_out_sym = r_pend_sym;
                    n_out_has = 1'b1;
                    n_out_end = 1'b0;
                    n_out_ovf = r_ovf;
                    n_pend_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (have_top) begin
                    if (top != OP_OPEN) begin
                        emit_req = 1'b1;
                        if (can_emit) begin
                            n_count = r_count - CW'(1);
                        end
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end else if (o_free) begin
                    // last word carries the end mark, bare marker if nothing came out
                    n_out_v   = 1'b1;
                    n_out_sym = r_pend_v ? r_pend_sym : 8'h00;
                    n_out_has = r_pend_v;
                    n_out_end = 1'b1;
                    n_out_ovf = r_ovf;
                    n_pend_v  = 1'b0;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one word held back so the end mark can land on the last one
        if (emit_req && can_emit) begin
            if (r_pend_v) begin
                n_out_v   = 1'b1;
                n_out_sym = r_pend_sym;
                n_out_has = 1'b1;
                n_out_end = 1'b0;
                n_out_ovf = r_ovf;
            end
            n_pend_v   = 1'b1;
            n_pend_sym = emit_ch;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {7'b0, r_out_ovf, r_out_sym};
    assign m_axis_tuser  = r_out_has;
    assign m_axis_tlast  = r_out_end;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held word left over at idle");

    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
        else $error("bare word without end mark");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && !have_top && o_free) |=> (r_count == '0 && !r_ovf))
        else $error("stack not cleared after end");

endmodule

`default_nettype wire
